// ===== src/msgd_pkg.sv =====
// ----------------------------------------------------------------------------
// msgd_pkg
// Shared types, constants and command codes for the minibatch gradient
// descent linear regression unit.
// ----------------------------------------------------------------------------
package msgd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 64;
  localparam int LR_FRAC   = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 16;
  localparam int NORM_W    = DATA_W - 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = 2 * DATA_W + 2;
  localparam int RAD_W     = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = $clog2(ACC_WIDTH);

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ACC_WIDTH - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(RAD_W / 2 - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT_INIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_INIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EPOCH    = 3'd4;

  localparam logic [15:0]      LR_RESET    = 16'd655;
  localparam logic [CNT_W-1:0] BSIZE_RESET = 16'd16;
  localparam logic [CNT_W-1:0] EPOCH_RESET = 16'd1;

  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [RAD_W-1:0] SQRT_BIT0 = {2'b01, {(RAD_W-2){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
    logic                     last_sample;
  } sample_t;

  typedef struct packed {
    logic [CNT_W-1:0]         epoch_number;
    logic [CNT_W-1:0]         batch_index;
    logic signed [DATA_W-1:0] intercept;
    logic signed [DATA_W-1:0] slope;
    logic [NORM_W-1:0]        gradient_norm;
    logic                     epoch_done;
  } result_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RESID,
    OP_MUL_RX,
    OP_ACC,
    OP_DIV_LOAD0,
    OP_DIV_LOAD1,
    OP_DIV_STEP,
    OP_DIV_END0,
    OP_DIV_END1,
    OP_MUL_LR0,
    OP_UPD0,
    OP_MUL_LR1,
    OP_UPD1,
    OP_SQ0,
    OP_SQ1,
    OP_SQ_ADD,
    OP_SQRT_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    logic result_free;
  } dp_status_t;

endpackage

// ===== src/msgd_dp.sv =====
// ----------------------------------------------------------------------------
// msgd_dp
// Datapath: configuration, coefficients, accumulators, shared multiplier,
// restoring divider, square root unit and the result word register.
// ----------------------------------------------------------------------------
module msgd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  msgd_pkg::dp_cmd_t                    cmd,
  output msgd_pkg::dp_status_t                 status,
  input  msgd_pkg::sample_t                    sample,
  input  logic                                 cfg_write,
  input  logic [msgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msgd_pkg::DATA_W-1:0]          cfg_data,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output msgd_pkg::result_t                    result
);

  typedef logic signed [msgd_pkg::WIDE_W-1:0]    wide_t;
  typedef logic signed [msgd_pkg::DATA_W:0]      mop_t;
  typedef logic signed [msgd_pkg::DATA_W-1:0]    word_t;
  typedef logic signed [msgd_pkg::ACC_WIDTH-1:0] acc_t;

  function automatic word_t sat_word(input wide_t v);
    logic [msgd_pkg::WIDE_W-msgd_pkg::DATA_W:0] hi;
    hi = v[msgd_pkg::WIDE_W-1:msgd_pkg::DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return v[msgd_pkg::DATA_W-1:0];
    end else if (v[msgd_pkg::WIDE_W-1]) begin
      return msgd_pkg::WORD_MIN;
    end else begin
      return msgd_pkg::WORD_MAX;
    end
  endfunction

  function automatic acc_t sat_acc(input wide_t v);
    logic [msgd_pkg::WIDE_W-msgd_pkg::ACC_WIDTH:0] hi;
    hi = v[msgd_pkg::WIDE_W-1:msgd_pkg::ACC_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      return v[msgd_pkg::ACC_WIDTH-1:0];
    end else if (v[msgd_pkg::WIDE_W-1]) begin
      return msgd_pkg::ACC_MIN;
    end else begin
      return msgd_pkg::ACC_MAX;
    end
  endfunction

  logic [15:0]                   lr;
  logic [msgd_pkg::CNT_W-1:0]    bsize;
  word_t                         b0;
  word_t                         b1;
  acc_t                          rsum;
  acc_t                          rxsum;
  logic [msgd_pkg::CNT_W-1:0]    cnt;
  logic [msgd_pkg::CNT_W-1:0]    batch_cnt;
  logic [msgd_pkg::CNT_W-1:0]    epoch_cnt;

  word_t                         x;
  word_t                         y;
  logic                          last;
  logic signed [msgd_pkg::PROD_W-1:0] prod;
  word_t                         resid;
  logic [msgd_pkg::ACC_WIDTH-1:0] div_q;
  logic [msgd_pkg::CNT_W:0]      div_r;
  logic                          div_neg;
  word_t                         g0;
  word_t                         g1;
  logic [msgd_pkg::RAD_W-1:0]    sq;
  logic [msgd_pkg::RAD_W-1:0]    rad;
  logic [msgd_pkg::RAD_W-1:0]    root;
  logic [msgd_pkg::RAD_W-1:0]    sbit;

  mop_t                          mul_a;
  mop_t                          mul_b;
  wide_t                         mul_full;
  wide_t                         resid_wide;
  acc_t                          rsum_next;
  acc_t                          rxsum_next;
  word_t                         coef_sel;
  word_t                         upd_word;
  logic [msgd_pkg::CNT_W-1:0]    cnt_inc;
  logic [msgd_pkg::CNT_W:0]      n;
  acc_t                          rsel;
  logic [msgd_pkg::ACC_WIDTH-1:0] acc_abs;
  logic [msgd_pkg::CNT_W+1:0]    rem_sh;
  logic [msgd_pkg::CNT_W+1:0]    rem_diff;
  logic                          rem_ge;
  logic                          rnd;
  logic                          q_big;
  logic [msgd_pkg::DATA_W:0]     mag;
  word_t                         g_new;
  logic [msgd_pkg::RAD_W-1:0]    trial;
  logic [msgd_pkg::NORM_W-1:0]   norm;
  logic                          result_free;
  logic                          emit_go;

  always_comb begin
    unique case (cmd.op)
      msgd_pkg::OP_LOAD: begin
        mul_a = mop_t'(b1);
        mul_b = mop_t'($signed(sample.x_value));
      end
      msgd_pkg::OP_MUL_RX: begin
        mul_a = mop_t'(resid);
        mul_b = mop_t'(x);
      end
      msgd_pkg::OP_MUL_LR0: begin
        mul_a = mop_t'(lr);
        mul_b = mop_t'(g0);
      end
      msgd_pkg::OP_MUL_LR1: begin
        mul_a = mop_t'(lr);
        mul_b = mop_t'(g1);
      end
      msgd_pkg::OP_SQ0: begin
        mul_a = mop_t'(g0);
        mul_b = mop_t'(g0);
      end
      msgd_pkg::OP_SQ1: begin
        mul_a = mop_t'(g1);
        mul_b = mop_t'(g1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign resid_wide = wide_t'(y) - wide_t'(b0) - wide_t'(prod >>> msgd_pkg::FRAC_BITS);
  assign rsum_next  = sat_acc(wide_t'(rsum) + wide_t'(resid));
  assign rxsum_next = sat_acc(wide_t'(rxsum) + wide_t'(prod >>> msgd_pkg::FRAC_BITS));

  assign coef_sel = (cmd.op == msgd_pkg::OP_UPD1) ? b1 : b0;
  assign upd_word = sat_word(wide_t'(coef_sel) - wide_t'(prod >>> msgd_pkg::LR_FRAC));

  assign cnt_inc = cnt + 1'b1;
  assign n       = {cnt == '0, cnt};

  assign rsel    = (cmd.op == msgd_pkg::OP_DIV_LOAD1) ? rxsum : rsum;
  assign acc_abs = rsel[msgd_pkg::ACC_WIDTH-1] ? -rsel : rsel;

  assign rem_sh   = {div_r, div_q[msgd_pkg::ACC_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, n};
  assign rem_ge   = rem_sh >= {1'b0, n};
  assign rnd      = {div_r, 1'b0} >= {1'b0, n};
  assign q_big    = (|div_q[msgd_pkg::ACC_WIDTH-1:msgd_pkg::DATA_W]) ||
                    (div_q[msgd_pkg::DATA_W-1] && (|div_q[msgd_pkg::DATA_W-2:0]));
  assign mag      = {div_q[msgd_pkg::DATA_W-1:0], rnd};

  always_comb begin
    if (div_neg) begin
      if (q_big || mag > {2'b00, {(msgd_pkg::DATA_W-1){1'b1}}}) begin
        g_new = msgd_pkg::WORD_MAX;
      end else begin
        g_new = word_t'(mag[msgd_pkg::DATA_W-1:0]);
      end
    end else begin
      if (q_big || mag > {2'b01, {(msgd_pkg::DATA_W-1){1'b0}}}) begin
        g_new = msgd_pkg::WORD_MIN;
      end else begin
        g_new = -word_t'(mag[msgd_pkg::DATA_W-1:0]);
      end
    end
  end

  assign trial = root + sbit;
  assign norm  = (|root[msgd_pkg::RAD_W-1:msgd_pkg::NORM_W]) ? '1 : root[msgd_pkg::NORM_W-1:0];

  assign result_free = !result_valid || !result_stall;
  assign emit_go     = (cmd.op == msgd_pkg::OP_EMIT) && result_free;

  assign status.close       = last || (cnt_inc >= bsize);
  assign status.result_free = result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      lr           <= msgd_pkg::LR_RESET;
      bsize        <= msgd_pkg::BSIZE_RESET;
      b0           <= '0;
      b1           <= '0;
      rsum         <= '0;
      rxsum        <= '0;
      cnt          <= '0;
      batch_cnt    <= '0;
      epoch_cnt    <= msgd_pkg::EPOCH_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          msgd_pkg::CFG_LEARNING_RATE:  lr        <= cfg_data[15:0];
          msgd_pkg::CFG_BATCH_SIZE:     bsize     <= cfg_data[msgd_pkg::CNT_W-1:0];
          msgd_pkg::CFG_INTERCEPT_INIT: b0        <= cfg_data;
          msgd_pkg::CFG_SLOPE_INIT:     b1        <= cfg_data;
          msgd_pkg::CFG_FIRST_EPOCH:    epoch_cnt <= cfg_data[msgd_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        msgd_pkg::OP_ACC: begin
          rsum  <= rsum_next;
          rxsum <= rxsum_next;
          cnt   <= cnt_inc;
        end
        msgd_pkg::OP_UPD0: b0 <= upd_word;
        msgd_pkg::OP_UPD1: b1 <= upd_word;
        msgd_pkg::OP_EMIT: begin
          if (result_free) begin
            rsum  <= '0;
            rxsum <= '0;
            cnt   <= '0;
            if (last) begin
              batch_cnt <= '0;
              epoch_cnt <= epoch_cnt + 1'b1;
            end else begin
              batch_cnt <= batch_cnt + 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_full[msgd_pkg::PROD_W-1:0];
    unique case (cmd.op)
      msgd_pkg::OP_LOAD: begin
        x    <= sample.x_value;
        y    <= sample.y_value;
        last <= sample.last_sample;
      end
      msgd_pkg::OP_RESID: resid <= sat_word(resid_wide);
      msgd_pkg::OP_DIV_LOAD0, msgd_pkg::OP_DIV_LOAD1: begin
        div_neg <= rsel[msgd_pkg::ACC_WIDTH-1];
        div_q   <= acc_abs;
        div_r   <= '0;
      end
      msgd_pkg::OP_DIV_STEP: begin
        div_r <= rem_ge ? rem_diff[msgd_pkg::CNT_W:0] : rem_sh[msgd_pkg::CNT_W:0];
        div_q <= {div_q[msgd_pkg::ACC_WIDTH-2:0], rem_ge};
      end
      msgd_pkg::OP_DIV_END0: g0 <= g_new;
      msgd_pkg::OP_DIV_END1: g1 <= g_new;
      msgd_pkg::OP_SQ1: sq <= $unsigned(prod);
      msgd_pkg::OP_SQ_ADD: begin
        rad  <= sq + $unsigned(prod);
        root <= '0;
        sbit <= msgd_pkg::SQRT_BIT0;
      end
      msgd_pkg::OP_SQRT_STEP: begin
        if (rad >= trial) begin
          rad  <= rad - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      msgd_pkg::OP_EMIT: begin
        if (result_free) begin
          result.epoch_number  <= epoch_cnt;
          result.batch_index   <= batch_cnt + 1'b1;
          result.intercept     <= b0;
          result.slope         <= b1;
          result.gradient_norm <= norm;
          result.epoch_done    <= last;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/msgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// msgd_ctrl
// Sequencer: steps the datapath through residual, accumulate, divide,
// update, square root and result load.
// ----------------------------------------------------------------------------
module msgd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  msgd_pkg::dp_status_t status,
  output msgd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_RESID,
    S_MUL_RX,
    S_ACC,
    S_DIV0_LOAD,
    S_DIV0_RUN,
    S_DIV0_END,
    S_DIV1_LOAD,
    S_DIV1_RUN,
    S_DIV1_END,
    S_LR0,
    S_UPD0,
    S_LR1,
    S_UPD1,
    S_SQ0,
    S_SQ1,
    S_SQ_ADD,
    S_SQRT_RUN,
    S_EMIT
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [msgd_pkg::STEP_W-1:0] step_cnt;
  logic                        accept;

  assign accept = sample_valid && !sample_stall;

  always_comb begin
    state_next = state;
    cmd.op     = msgd_pkg::OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op     = msgd_pkg::OP_LOAD;
          state_next = S_RESID;
        end
      end
      S_RESID: begin
        cmd.op     = msgd_pkg::OP_RESID;
        state_next = S_MUL_RX;
      end
      S_MUL_RX: begin
        cmd.op     = msgd_pkg::OP_MUL_RX;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = msgd_pkg::OP_ACC;
        state_next = status.close ? S_DIV0_LOAD : S_IDLE;
      end
      S_DIV0_LOAD: begin
        cmd.op     = msgd_pkg::OP_DIV_LOAD0;
        state_next = S_DIV0_RUN;
      end
      S_DIV0_RUN: begin
        cmd.op = msgd_pkg::OP_DIV_STEP;
        if (step_cnt == msgd_pkg::DIV_LAST) begin
          state_next = S_DIV0_END;
        end
      end
      S_DIV0_END: begin
        cmd.op     = msgd_pkg::OP_DIV_END0;
        state_next = S_DIV1_LOAD;
      end
      S_DIV1_LOAD: begin
        cmd.op     = msgd_pkg::OP_DIV_LOAD1;
        state_next = S_DIV1_RUN;
      end
      S_DIV1_RUN: begin
        cmd.op = msgd_pkg::OP_DIV_STEP;
        if (step_cnt == msgd_pkg::DIV_LAST) begin
          state_next = S_DIV1_END;
        end
      end
      S_DIV1_END: begin
        cmd.op     = msgd_pkg::OP_DIV_END1;
        state_next = S_LR0;
      end
      S_LR0: begin
        cmd.op     = msgd_pkg::OP_MUL_LR0;
        state_next = S_UPD0;
      end
      S_UPD0: begin
        cmd.op     = msgd_pkg::OP_UPD0;
        state_next = S_LR1;
      end
      S_LR1: begin
        cmd.op     = msgd_pkg::OP_MUL_LR1;
        state_next = S_UPD1;
      end
      S_UPD1: begin
        cmd.op     = msgd_pkg::OP_UPD1;
        state_next = S_SQ0;
      end
      S_SQ0: begin
        cmd.op     = msgd_pkg::OP_SQ0;
        state_next = S_SQ1;
      end
      S_SQ1: begin
        cmd.op     = msgd_pkg::OP_SQ1;
        state_next = S_SQ_ADD;
      end
      S_SQ_ADD: begin
        cmd.op     = msgd_pkg::OP_SQ_ADD;
        state_next = S_SQRT_RUN;
      end
      S_SQRT_RUN: begin
        cmd.op = msgd_pkg::OP_SQRT_STEP;
        if (step_cnt == msgd_pkg::SQRT_LAST) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.op = msgd_pkg::OP_EMIT;
        if (status.result_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_cnt     <= '0;
      sample_stall <= 1'b0;
    end else begin
      state        <= state_next;
      sample_stall <= (state_next != S_IDLE);
      if (state == S_DIV0_RUN || state == S_DIV1_RUN || state == S_SQRT_RUN) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

endmodule

// ===== src/minibatch_sgd_linear_regression_unit.sv =====
// A sample that leaves its batch open passes through the residual, multiply
//   and accumulate steps; no new sample is taken until they finish.
// A sample that closes a batch then also runs two 64-step restoring divides
//   on one shared divider and a 32-step square root, and its result word is
//   registered once the output is free.
// Reset (rst, synchronous): register defaults, coefficients, sums and counters.
// ----------------------------------------------------------------------------
// minibatch_sgd_linear_regression_unit
// Minibatch gradient descent fit of y = b0 + b1*x over streamed Q16.16 samples.
// ----------------------------------------------------------------------------
module minibatch_sgd_linear_regression_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  msgd_pkg::sample_t              sample,
  input  logic                           cfg_write,
  input  logic [msgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msgd_pkg::DATA_W-1:0]    cfg_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output msgd_pkg::result_t              result
);

  msgd_pkg::dp_cmd_t    cmd;
  msgd_pkg::dp_status_t status;

  msgd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  msgd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== src/msgd_checker.sv =====
// ----------------------------------------------------------------------------
// msgd_checker
// Port-level checks on the regression unit, bound to the top level.
// ----------------------------------------------------------------------------
module msgd_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input msgd_pkg::result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall ##1 sample_stall ##1 sample_stall)
    else $error("sample word taken before the previous one finished");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result word loaded while samples were open");

endmodule

bind minibatch_sgd_linear_regression_unit msgd_checker u_msgd_checker (.*);

// ===== dv/minibatch_sgd_linear_regression_unit_tb.sv =====
// ----------------------------------------------------------------------------
// minibatch_sgd_linear_regression_unit_tb
// Streams Q16.16 samples through the regression unit under random valid and
// stall gaps. A scoreboard predicts every coefficient update word from its
// own copy of the settings, sums and counters, and each result word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module minibatch_sgd_linear_regression_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class regression_scoreboard;
    logic [15:0]                  learn_rate;
    logic [15:0]                  batch_len;
    logic signed [31:0]           coef_b0;
    logic signed [31:0]           coef_b1;
    logic signed [63:0]           resid_acc;
    logic signed [63:0]           resid_x_acc;
    logic [15:0]                  fill;
    logic [15:0]                  batch_num;
    logic [15:0]                  epoch_num;
    msgd_pkg::result_t            updates[$];
    int                           errors;

    function new();
      learn_rate  = msgd_pkg::LR_RESET;
      batch_len   = msgd_pkg::BSIZE_RESET;
      coef_b0     = '0;
      coef_b1     = '0;
      resid_acc   = '0;
      resid_x_acc = '0;
      fill        = '0;
      batch_num   = '0;
      epoch_num   = msgd_pkg::EPOCH_RESET;
      errors      = 0;
    endfunction

    static function logic signed [31:0] sat_word(longint v);
      if (v > longint'(msgd_pkg::WORD_MAX)) return msgd_pkg::WORD_MAX;
      if (v < longint'(msgd_pkg::WORD_MIN)) return msgd_pkg::WORD_MIN;
      return v[31:0];
    endfunction

    static function logic signed [63:0] acc_add(logic signed [63:0] acc, longint t);
      logic signed [64:0] s;
      s = 65'(acc);
      s = s + 65'(t);
      if (s > 65'(msgd_pkg::ACC_MAX)) return msgd_pkg::ACC_MAX;
      if (s < 65'(msgd_pkg::ACC_MIN)) return msgd_pkg::ACC_MIN;
      return s[63:0];
    endfunction

    // -2 * total / count, rounded as the divider does, saturated to a word
    static function logic signed [31:0] mean_gradient(logic signed [63:0] total,
                                                       logic [15:0] count);
      logic [63:0] n;
      logic [63:0] mag_in;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] mag;
      n = (count == 0) ? 64'd65536 : 64'(count);
      mag_in = total[63] ? 64'(-total) : 64'(total);
      quo = mag_in / n;
      rem = mag_in % n;
      if (quo > 64'h8000_0000) mag = 64'h1_0000_0000;
      else mag = 64'd2 * quo + ((64'd2 * rem >= n) ? 64'd1 : 64'd0);
      return sat_word(total[63] ? longint'(mag) : -longint'(mag));
    endfunction

    static function logic [msgd_pkg::NORM_W-1:0] norm_of(longint g0, longint g1);
      logic [63:0] radicand;
      logic [32:0] root;
      logic [32:0] trial;
      logic [65:0] square;
      radicand = 64'(g0 * g0);
      radicand = radicand + 64'(g1 * g1);
      root = '0;
      for (int i = 32; i >= 0; i--) begin
        trial = root | (33'd1 << i);
        square = 66'(trial) * 66'(trial);
        if (square <= 66'(radicand)) root = trial;
      end
      return (root > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
    endfunction

    function void configure(logic [msgd_pkg::CFG_IDX_W-1:0] idx,
                            logic [msgd_pkg::DATA_W-1:0] data);
      case (idx)
        msgd_pkg::CFG_LEARNING_RATE:  learn_rate = data[15:0];
        msgd_pkg::CFG_BATCH_SIZE:     batch_len = data[15:0];
        msgd_pkg::CFG_INTERCEPT_INIT: coef_b0 = data;
        msgd_pkg::CFG_SLOPE_INIT:     coef_b1 = data;
        msgd_pkg::CFG_FIRST_EPOCH:    epoch_num = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_sample(msgd_pkg::sample_t s);
      longint            xv;
      longint            yv;
      longint            resid;
      longint            g0;
      longint            g1;
      msgd_pkg::result_t fit;
      xv = longint'(s.x_value);
      yv = longint'(s.y_value);
      resid = longint'(sat_word(yv - longint'(coef_b0) -
                                ((longint'(coef_b1) * xv) >>> msgd_pkg::FRAC_BITS)));
      resid_acc = acc_add(resid_acc, resid);
      resid_x_acc = acc_add(resid_x_acc, (resid * xv) >>> msgd_pkg::FRAC_BITS);
      fill = fill + 1'b1;
      if (!s.last_sample && fill < batch_len) return;
      g0 = longint'(mean_gradient(resid_acc, fill));
      g1 = longint'(mean_gradient(resid_x_acc, fill));
      coef_b0 = sat_word(longint'(coef_b0) -
                         ((longint'(learn_rate) * g0) >>> msgd_pkg::LR_FRAC));
      coef_b1 = sat_word(longint'(coef_b1) -
                         ((longint'(learn_rate) * g1) >>> msgd_pkg::LR_FRAC));
      batch_num = batch_num + 1'b1;
      fit.epoch_number  = epoch_num;
      fit.batch_index   = batch_num;
      fit.intercept     = coef_b0;
      fit.slope         = coef_b1;
      fit.gradient_norm = norm_of(g0, g1);
      fit.epoch_done    = s.last_sample;
      updates.push_back(fit);
      resid_acc   = '0;
      resid_x_acc = '0;
      fill        = '0;
      if (s.last_sample) begin
        batch_num = '0;
        epoch_num = epoch_num + 1'b1;
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(msgd_pkg::result_t got);
      msgd_pkg::result_t want;
      if (updates.size() == 0) begin
        $error("result word with no update pending");
        errors++;
        return;
      end
      want = updates.pop_front();
      compare("epoch_number", longint'(want.epoch_number), longint'(got.epoch_number));
      compare("batch_index", longint'(want.batch_index), longint'(got.batch_index));
      compare("intercept", longint'(want.intercept), longint'(got.intercept));
      compare("slope", longint'(want.slope), longint'(got.slope));
      compare("gradient_norm", longint'(want.gradient_norm),
              longint'(got.gradient_norm));
      compare("epoch_done", longint'(want.epoch_done), longint'(got.epoch_done));
    endfunction

    function int pending();
      return updates.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  msgd_pkg::sample_t              sample = '0;
  logic                           cfg_write = 1'b0;
  logic [msgd_pkg::CFG_IDX_W-1:0] cfg_index = msgd_pkg::CFG_LEARNING_RATE;
  logic [msgd_pkg::DATA_W-1:0]    cfg_data = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  msgd_pkg::result_t              result;

  int tx_idle_pct = 9;
  int rx_idle_pct = 65;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  regression_scoreboard fit_board = new();

  minibatch_sgd_linear_regression_unit dut (
    .clk,
    .rst,
    .sample_valid,
    .sample_stall,
    .sample,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .result_valid,
    .result_stall,
    .result
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) fit_board.check_result(result);
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic msgd_pkg::sample_t sample_of(logic signed [31:0] x,
                                                  logic signed [31:0] y, logic last);
    msgd_pkg::sample_t s;
    s.x_value = x;
    s.y_value = y;
    s.last_sample = last;
    return s;
  endfunction

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(6))
      0: return msgd_pkg::WORD_MAX;
      1: return msgd_pkg::WORD_MIN;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return 32'sd65536;
      default: return -32'sd65536;
    endcase
  endfunction

  // mostly points near the line y = a + c*x, with some full-range and corner words
  function automatic msgd_pkg::sample_t random_sample(longint a, longint c, int last_pct);
    int     pick;
    longint xv;
    longint yv;
    logic   last;
    pick = $urandom_range(99);
    last = ($urandom_range(99) < last_pct);
    if (pick < 10) begin
      return sample_of($urandom, $urandom, last);
    end else if (pick < 18) begin
      return sample_of(corner_value(), corner_value(), last);
    end
    xv = longint'($urandom_range(1048576)) - 524288;
    yv = a + ((c * xv) >>> msgd_pkg::FRAC_BITS) + longint'($urandom_range(131072)) - 65536;
    return sample_of(32'(xv), 32'(yv), last);
  endfunction

  task automatic send_sample(msgd_pkg::sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_valid <= 1'b0;
      sample <= sample_of($urandom, $urandom, 1'($urandom_range(1)));
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    fit_board.note_sample(s);
  endtask

  task automatic stream_phase(int count, int last_pct);
    longint a;
    longint c;
    a = longint'($urandom_range(524288)) - 262144;
    c = longint'($urandom_range(524288)) - 262144;
    repeat (count) send_sample(random_sample(a, c, last_pct));
  endtask

  task automatic drain(int settle);
    sample_valid <= 1'b0;
    while (fit_board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [msgd_pkg::CFG_IDX_W-1:0] idx,
                           logic [msgd_pkg::DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    fit_board.configure(idx, data);
  endtask

  task automatic load_settings(logic [15:0] lr, logic [15:0] bs, logic [31:0] b0,
                               logic [31:0] b1, logic [15:0] ep);
    write_reg(msgd_pkg::CFG_LEARNING_RATE, 32'(lr));
    write_reg(msgd_pkg::CFG_BATCH_SIZE, 32'(bs));
    write_reg(msgd_pkg::CFG_INTERCEPT_INIT, b0);
    write_reg(msgd_pkg::CFG_SLOPE_INIT, b1);
    write_reg(msgd_pkg::CFG_FIRST_EPOCH, 32'(ep));
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_sample(sample_of(32'sd65536, 32'sd196608, 1'b0));
    send_sample(sample_of(32'sd131072, 32'sd327680, 1'b0));
    send_sample(sample_of(msgd_pkg::WORD_MAX, msgd_pkg::WORD_MIN, 1'b0));
    send_sample(sample_of(msgd_pkg::WORD_MIN, msgd_pkg::WORD_MAX, 1'b1));
    send_sample(sample_of(32'sd0, 32'sd0, 1'b1));
    drain(16);

    load_settings(16'hFFFF, 16'd4, msgd_pkg::WORD_MIN, msgd_pkg::WORD_MAX, 16'hFFFF);
    send_sample(sample_of(msgd_pkg::WORD_MAX, msgd_pkg::WORD_MAX, 1'b0));
    send_sample(sample_of(msgd_pkg::WORD_MIN, msgd_pkg::WORD_MIN, 1'b0));
    send_sample(sample_of(-32'sd1, 32'sd1, 1'b0));
    send_sample(sample_of(msgd_pkg::WORD_MAX, 32'sd0, 1'b1));
    send_sample(sample_of(32'sd1, -32'sd1, 1'b0));
    send_sample(sample_of(32'sd65536, -32'sd65536, 1'b0));
    send_sample(sample_of(32'sd0, msgd_pkg::WORD_MAX, 1'b0));
    send_sample(sample_of(msgd_pkg::WORD_MIN, 32'sd0, 1'b0));
    send_sample(sample_of(-32'sd65536, 32'sd131072, 1'b1));
    drain(16);

    load_settings(16'd0, 16'd0, msgd_pkg::WORD_MAX, msgd_pkg::WORD_MIN, 16'd0);
    send_sample(sample_of(msgd_pkg::WORD_MAX, msgd_pkg::WORD_MAX, 1'b0));
    send_sample(sample_of(msgd_pkg::WORD_MIN, -32'sd1, 1'b0));
    send_sample(sample_of(32'sd0, 32'sd0, 1'b0));
    send_sample(sample_of(32'sd1, 32'sd1, 1'b1));
    drain(16);

    load_settings(msgd_pkg::LR_RESET, 16'd3, $urandom, $urandom,
                  16'($urandom_range(65535)));
    stream_phase(290, 5);
    drain(16);
    load_settings(16'd0, 16'd1, 32'd0, 32'd0, 16'hFFFE);
    stream_phase(290, 10);
    drain(16);

    tx_idle_pct = 65;
    rx_idle_pct = 9;
    load_settings(16'hFFFF, 16'd7, 32'(longint'($urandom_range(262144)) - 131072),
                  32'(longint'($urandom_range(262144)) - 131072),
                  16'($urandom_range(65535)));
    stream_phase(290, 5);
    drain(16);
    load_settings(16'($urandom_range(65535)), 16'd0,
                  32'(longint'($urandom_range(262144)) - 131072),
                  32'(longint'($urandom_range(262144)) - 131072),
                  16'($urandom_range(65535)));
    stream_phase(290, 10);
    drain(16);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_settings(16'($urandom_range(65535)), 16'hFFFF, $urandom, $urandom,
                  16'($urandom_range(65535)));
    stream_phase(290, 4);
    drain(16);
    load_settings(16'($urandom_range(65535)), 16'($urandom_range(4, 1)),
                  32'(longint'($urandom_range(262144)) - 131072),
                  32'(longint'($urandom_range(262144)) - 131072),
                  16'($urandom_range(65535)));
    // hold the result side so the unit backs up into its input
    hold_requests = hold_requests + 1;
    stream_phase(290, 8);
    drain(200);

    if (fit_board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
